FILE: src/terrain_bilinear_height_sampler_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the terrain height sampler.
// Each macro builds one clocked property that is disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef TERRAIN_BILINEAR_HEIGHT_SAMPLER_DEFINES_SVH
`define TERRAIN_BILINEAR_HEIGHT_SAMPLER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TBHS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TBHS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/tbhs_pkg.sv
// ----------------------------------------------------------------------------
// tbhs_pkg
// Shared types and constants of the terrain height sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package tbhs_pkg;

    // Default geometry of the map.
    localparam int DEF_CHUNKS_PER_ROW      = 16;
    localparam int DEF_TILES_PER_CHUNK_ROW = 4;
    localparam int DEF_TILE_PIXEL_WIDTH    = 512;
    localparam int DEF_POS_FRAC_BITS       = 8;

    // Field widths.
    localparam int CORNER_W = 16;
    localparam int POS_W    = 25;
    localparam int HEIGHT_W = 24;
    localparam int FRAC_W   = 8;
    localparam int TCOORD_W = 6;

    // Tile store: 64 x 64 tiles of four corners each.
    localparam int STORE_SIDE_W = 6;
    localparam int STORE_SIDE   = 64;
    localparam int STORE_AW     = 2 * STORE_SIDE_W;
    localparam int STORE_DEPTH  = STORE_SIDE * STORE_SIDE;
    localparam int TILE_W       = 4 * CORNER_W;

    // Result queue depth; a power of two.
    localparam int FIFO_DEPTH = 8;

    // Item function codes.
    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_QUERY = 1'b1
    } t_func;

    // Located item, as it leaves the position unit and meets the tile store.
    typedef struct packed {
        logic                    valid;
        logic                    query;
        logic                    out_of_range;
        logic                    beyond;
        logic                    we;
        logic [STORE_AW-1:0]     addr;
        logic [FRAC_W-1:0]       fx;
        logic [FRAC_W-1:0]       fy;
        logic [TILE_W-1:0]       wdata;
    } t_loc;

    // Finished query result.
    typedef struct packed {
        logic                    valid;
        logic                    in_range;
        logic [HEIGHT_W-1:0]     height;
    } t_res;

endpackage

`default_nettype wire

FILE: src/tbhs_ram.sv
// ----------------------------------------------------------------------------
// tbhs_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tbhs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: src/tbhs_locate.sv
// ----------------------------------------------------------------------------
// tbhs_locate
// Three-stage position unit: range check, tile index and in-tile fraction
// by reciprocal multiply with one correction step, and tile store address.
// ----------------------------------------------------------------------------
`default_nettype none

module tbhs_locate
    import tbhs_pkg::*;
#(
    parameter int CHUNKS_PER_ROW      = DEF_CHUNKS_PER_ROW,
    parameter int TILES_PER_CHUNK_ROW = DEF_TILES_PER_CHUNK_ROW,
    parameter int TILE_PIXEL_WIDTH    = DEF_TILE_PIXEL_WIDTH,
    parameter int POS_FRAC_BITS       = DEF_POS_FRAC_BITS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_beat,
    input  wire logic [0:0]          i_func,
    input  wire logic [TCOORD_W-1:0] i_tile_col,
    input  wire logic [TCOORD_W-1:0] i_tile_row,
    input  wire logic [CORNER_W-1:0] i_corner_nw,
    input  wire logic [CORNER_W-1:0] i_corner_ne,
    input  wire logic [CORNER_W-1:0] i_corner_sw,
    input  wire logic [CORNER_W-1:0] i_corner_se,
    input  wire logic [POS_W-1:0]    i_pos_x,
    input  wire logic [POS_W-1:0]    i_pos_y,
    output t_loc                     o_loc
);

    // Map geometry and the divisor of one tile in position units.
    localparam int MAP_TILES = CHUNKS_PER_ROW * TILES_PER_CHUNK_ROW;
    localparam int COL_W     = (MAP_TILES > 1) ? $clog2(MAP_TILES) : 1;
    localparam int QW        = COL_W + FRAC_W;
    localparam int UPOS_W    = POS_W - 1;
    localparam logic [63:0] DIVISOR   = 64'(TILE_PIXEL_WIDTH) << POS_FRAC_BITS;
    localparam logic [63:0] POS_LIMIT = (64'(MAP_TILES) * 64'(TILE_PIXEL_WIDTH))
                                        << POS_FRAC_BITS;
    localparam logic [31:0] RECIP     = 32'((64'd1 << 32) / DIVISOR);
    localparam logic [31:0] DIV32     = 32'(DIVISOR);
    localparam logic [31:0] TILES32   = 32'(MAP_TILES);
    localparam logic [31:0] SIDE32    = 32'(STORE_SIDE);

    // ------------------------------------------------------------------
    // Stage 1: range check and the reciprocal estimate of the quotient.
    // ------------------------------------------------------------------
    logic [UPOS_W-1:0] ux, uy;
    logic [31:0]       nx, ny;
    logic [63:0]       est_x, est_y;
    logic              oor;
    logic              wr_ok;

    assign ux    = i_pos_x[UPOS_W-1:0];
    assign uy    = i_pos_y[UPOS_W-1:0];
    assign nx    = {ux, {FRAC_W{1'b0}}};
    assign ny    = {uy, {FRAC_W{1'b0}}};
    assign est_x = 64'(nx) * 64'(RECIP);
    assign est_y = 64'(ny) * 64'(RECIP);
    assign oor   = i_pos_x[POS_W-1] | i_pos_y[POS_W-1]
                 | (64'(ux) >= POS_LIMIT) | (64'(uy) >= POS_LIMIT);
    assign wr_ok = (32'(i_tile_col) < TILES32) && (32'(i_tile_row) < TILES32);

    logic                r1_valid;
    logic                r1_query;
    logic                r1_oor;
    logic                r1_wr_ok;
    logic [STORE_AW-1:0] r1_waddr;
    logic [TILE_W-1:0]   r1_wdata;
    logic [31:0]         r1_nx, r1_ny;
    logic [QW-1:0]       r1_q0x, r1_q0y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_query <= (i_func == FUNC_QUERY);
        r1_oor   <= oor;
        r1_wr_ok <= wr_ok;
        r1_waddr <= {i_tile_row, i_tile_col};
        r1_wdata <= {i_corner_se, i_corner_sw, i_corner_ne, i_corner_nw};
        r1_nx    <= nx;
        r1_ny    <= ny;
        r1_q0x   <= est_x[32 +: QW];
        r1_q0y   <= est_y[32 +: QW];
    end

    // ------------------------------------------------------------------
    // Stage 2: multiply the estimate back by the divisor.
    // ------------------------------------------------------------------
    logic                r2_valid;
    logic                r2_query;
    logic                r2_oor;
    logic                r2_wr_ok;
    logic [STORE_AW-1:0] r2_waddr;
    logic [TILE_W-1:0]   r2_wdata;
    logic [31:0]         r2_nx, r2_ny;
    logic [QW-1:0]       r2_q0x, r2_q0y;
    logic [31:0]         r2_backx, r2_backy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_query <= r1_query;
        r2_oor   <= r1_oor;
        r2_wr_ok <= r1_wr_ok;
        r2_waddr <= r1_waddr;
        r2_wdata <= r1_wdata;
        r2_nx    <= r1_nx;
        r2_ny    <= r1_ny;
        r2_q0x   <= r1_q0x;
        r2_q0y   <= r1_q0y;
        r2_backx <= 32'(r1_q0x) * DIV32;
        r2_backy <= 32'(r1_q0y) * DIV32;
    end

    // ------------------------------------------------------------------
    // Stage 3: correct the quotient by one, split it into tile and
    // fraction, and form the tile store address.
    // ------------------------------------------------------------------
    logic [31:0]             rem_x, rem_y;
    logic [QW-1:0]           q_x, q_y;
    logic [COL_W-1:0]        col, row;
    logic                    beyond;
    logic [STORE_AW-1:0]     qaddr;

    assign rem_x  = r2_nx - r2_backx;
    assign rem_y  = r2_ny - r2_backy;
    assign q_x    = r2_q0x + QW'(rem_x >= DIV32);
    assign q_y    = r2_q0y + QW'(rem_y >= DIV32);
    assign col    = q_x[QW-1:FRAC_W];
    assign row    = q_y[QW-1:FRAC_W];
    assign beyond = (32'(col) >= SIDE32) || (32'(row) >= SIDE32);
    assign qaddr  = {STORE_SIDE_W'(row), STORE_SIDE_W'(col)};

    // The valid and write enable are reset; the rest only follows the item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_loc.valid <= 1'b0;
            o_loc.we    <= 1'b0;
        end else begin
            o_loc.valid <= r2_valid;
            o_loc.we    <= r2_valid && !r2_query && r2_wr_ok;
        end
        o_loc.query        <= r2_query;
        o_loc.out_of_range <= r2_oor;
        o_loc.beyond       <= beyond;
        o_loc.addr         <= r2_query ? qaddr : r2_waddr;
        o_loc.fx           <= q_x[FRAC_W-1:0];
        o_loc.fy           <= q_y[FRAC_W-1:0];
        o_loc.wdata        <= r2_wdata;
    end

endmodule

`default_nettype wire

FILE: src/tbhs_interp.sv
// ----------------------------------------------------------------------------
// tbhs_interp
// Bilinear interpolation of the four corners read from the tile store:
// one stage blends along x, the next blends along y and forms the result.
// ----------------------------------------------------------------------------
`default_nettype none

module tbhs_interp
    import tbhs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_loc              i_loc,
    input  wire logic [TILE_W-1:0] i_rdata,
    output t_res                   o_res
);

    // ------------------------------------------------------------------
    // Stage 4: item data alongside the tile store read.
    // ------------------------------------------------------------------
    logic              r4_valid;
    logic              r4_in_range;
    logic              r4_zero;
    logic [FRAC_W-1:0] r4_fx, r4_fy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else begin
            r4_valid <= i_loc.valid && i_loc.query;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_in_range <= !i_loc.out_of_range;
        r4_zero     <= i_loc.beyond;
        r4_fx       <= i_loc.fx;
        r4_fy       <= i_loc.fy;
    end

    // ------------------------------------------------------------------
    // Stage 5: blend the top and bottom edges along x.
    // ------------------------------------------------------------------
    logic [TILE_W-1:0]      corners;
    logic signed [15:0]     nw, ne, sw, se;
    logic signed [16:0]     d_top, d_bot;
    logic signed [8:0]      fx_s;
    logic signed [25:0]     p_top, p_bot, top_sum, bot_sum;

    assign corners = r4_zero ? '0 : i_rdata;
    assign nw      = corners[15:0];
    assign ne      = corners[31:16];
    assign sw      = corners[47:32];
    assign se      = corners[63:48];
    assign d_top   = {ne[15], ne} - {nw[15], nw};
    assign d_bot   = {se[15], se} - {sw[15], sw};
    assign fx_s    = {1'b0, r4_fx};
    assign p_top   = d_top * fx_s;
    assign p_bot   = d_bot * fx_s;
    assign top_sum = {{2{nw[15]}}, nw, 8'h00} + p_top;
    assign bot_sum = {{2{sw[15]}}, sw, 8'h00} + p_bot;

    logic               r5_valid;
    logic               r5_in_range;
    logic [FRAC_W-1:0]  r5_fy;
    logic signed [25:0] r5_top, r5_bot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else begin
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_in_range <= r4_in_range;
        r5_fy       <= r4_fy;
        r5_top      <= top_sum;
        r5_bot      <= bot_sum;
    end

    // ------------------------------------------------------------------
    // Stage 6: blend along y and drop the extra fraction bits.
    // ------------------------------------------------------------------
    logic signed [26:0] d_mid;
    logic signed [8:0]  fy_s;
    logic signed [35:0] p_mid, z;

    assign d_mid = {r5_bot[25], r5_bot} - {r5_top[25], r5_top};
    assign fy_s  = {1'b0, r5_fy};
    assign p_mid = d_mid * fy_s;
    assign z     = {{2{r5_top[25]}}, r5_top, 8'h00} + p_mid;

    // The valid is reset; the result fields only follow the item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_res.valid <= 1'b0;
        end else begin
            o_res.valid <= r5_valid;
        end
        o_res.in_range <= r5_in_range;
        o_res.height   <= r5_in_range ? z[31:8] : '0;
    end

endmodule

`default_nettype wire

FILE: src/terrain_bilinear_height_sampler.sv
// ----------------------------------------------------------------------------
// terrain_bilinear_height_sampler
// Path of a query: position unit, tile store read, interpolation, result queue.
// Throughput: one item per cycle; the tile store takes a write or a read each
// cycle, and an 8-entry result queue with credit count sets the input ready.
// Reset clears pipeline valids, queue and credits; the tile store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module terrain_bilinear_height_sampler
    import tbhs_pkg::*;
#(
    parameter int CHUNKS_PER_ROW      = DEF_CHUNKS_PER_ROW,
    parameter int TILES_PER_CHUNK_ROW = DEF_TILES_PER_CHUNK_ROW,
    parameter int TILE_PIXEL_WIDTH    = DEF_TILE_PIXEL_WIDTH,
    parameter int POS_FRAC_BITS       = DEF_POS_FRAC_BITS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [0:0]          i_func,
    input  wire logic [TCOORD_W-1:0] i_tile_col,
    input  wire logic [TCOORD_W-1:0] i_tile_row,
    input  wire logic [CORNER_W-1:0] i_corner_nw,
    input  wire logic [CORNER_W-1:0] i_corner_ne,
    input  wire logic [CORNER_W-1:0] i_corner_sw,
    input  wire logic [CORNER_W-1:0] i_corner_se,
    input  wire logic [POS_W-1:0]    i_pos_x,
    input  wire logic [POS_W-1:0]    i_pos_y,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic                     o_in_range,
    output logic [HEIGHT_W-1:0]      o_height
);

    `include "terrain_bilinear_height_sampler_defines.svh"

    localparam int FIFO_AW = $clog2(FIFO_DEPTH);
    localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);

    logic in_beat;
    logic out_beat;
    logic query_beat;
    t_loc loc;
    t_res res;
    logic [TILE_W-1:0] rdata;

    assign in_beat    = i_in_valid && o_in_ready;
    assign out_beat   = o_out_valid && i_out_ready;
    assign query_beat = in_beat && (i_func == FUNC_QUERY);

    // Position unit.
    tbhs_locate #(
        .CHUNKS_PER_ROW      (CHUNKS_PER_ROW),
        .TILES_PER_CHUNK_ROW (TILES_PER_CHUNK_ROW),
        .TILE_PIXEL_WIDTH    (TILE_PIXEL_WIDTH),
        .POS_FRAC_BITS       (POS_FRAC_BITS)
    ) u_locate (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_beat      (in_beat),
        .i_func      (i_func),
        .i_tile_col  (i_tile_col),
        .i_tile_row  (i_tile_row),
        .i_corner_nw (i_corner_nw),
        .i_corner_ne (i_corner_ne),
        .i_corner_sw (i_corner_sw),
        .i_corner_se (i_corner_se),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .o_loc       (loc)
    );

    // Tile store; writes and reads happen in item order at the same stage.
    tbhs_ram #(
        .WIDTH (TILE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (loc.we),
        .i_waddr (loc.addr),
        .i_wdata (loc.wdata),
        .i_re    (loc.valid && loc.query),
        .i_raddr (loc.addr),
        .o_rdata (rdata)
    );

    // Interpolation unit.
    tbhs_interp u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_loc   (loc),
        .i_rdata (rdata),
        .o_res   (res)
    );

    // Credit count: queries accepted whose result has not yet left.
    logic [CNT_W-1:0] r_pending, n_pending;

    always_comb begin
        n_pending = r_pending;
        if (query_beat && !out_beat) begin
            n_pending = r_pending + 1'b1;
        end else if (!query_beat && out_beat) begin
            n_pending = r_pending - 1'b1;
        end
    end

    assign o_in_ready = (r_pending < CNT_W'(FIFO_DEPTH));

    // Result queue.
    logic                r_q_range  [FIFO_DEPTH];
    logic [HEIGHT_W-1:0] r_q_height [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]    r_count, n_count;

    always_comb begin
        n_count = r_count;
        if (res.valid && !out_beat) begin
            n_count = r_count + 1'b1;
        end else if (!res.valid && out_beat) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_count   <= '0;
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
        end else begin
            r_pending <= n_pending;
            r_count   <= n_count;
            if (res.valid) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (out_beat) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid) begin
            r_q_range[r_wr_ptr]  <= res.in_range;
            r_q_height[r_wr_ptr] <= res.height;
        end
    end

    assign o_out_valid = (r_count != '0);
    assign o_in_range  = r_q_range[r_rd_ptr];
    assign o_height    = r_q_height[r_rd_ptr];

    // Checks on the credit scheme and the result queue.
    `TBHS_ASSERT_IMPLY(a_queue_room, i_clk, i_rst_n, res.valid, r_count < CNT_W'(FIFO_DEPTH), "result queue overflow")
    `TBHS_ASSERT_IMPLY(a_queue_credit, i_clk, i_rst_n, 1'b1, r_count <= r_pending, "queued results exceed credits")
    `TBHS_ASSERT_NEXT(a_credit_take, i_clk, i_rst_n, query_beat && !out_beat, r_pending == $past(r_pending) + 1'b1, "query beat did not take a credit")
    `TBHS_ASSERT_IMPLY(a_off_map_zero, i_clk, i_rst_n, o_out_valid && !o_in_range, o_height == '0, "off-map result with nonzero height")

endmodule

`default_nettype wire
